>>> design/qe_pkg.sv
package qe_pkg;

    localparam int SCALE_FRAC_BITS = 16;
    localparam int F24 = 24;
    localparam int QW = 10;
    localparam logic [QW-1:0] QCAP = {QW{1'b1}};
    // Widest numerator or denominator over all modes and the whole scale range.
    localparam int WW = 100;
    localparam int DW = WW + 1;
    localparam int RW = WW + 12;
    localparam int ACC_W = 26;
    localparam int XW = 42;
    localparam int TW = 31;
    localparam int PW = 61;
    localparam logic [29:0] LOG2E_Q28 = 30'd387270501;
    localparam logic signed [XW-1:0] EXP_LIM = XW'(32) <<< SCALE_FRAC_BITS;

    localparam logic [2:0] MODE_MUL = 3'd0;
    localparam logic [2:0] MODE_ADD = 3'd1;
    localparam logic [2:0] MODE_SUB = 3'd2;
    localparam logic [2:0] MODE_DIV = 3'd3;
    localparam logic [2:0] MODE_EXP = 3'd4;

    localparam logic [2:0] CFG_OP_MODE = 3'd0;
    localparam logic [2:0] CFG_ZP_A = 3'd1;
    localparam logic [2:0] CFG_ZP_B = 3'd2;
    localparam logic [2:0] CFG_ZP_OUT = 3'd3;
    localparam logic [2:0] CFG_SCALE_A = 3'd4;
    localparam logic [2:0] CFG_SCALE_B = 3'd5;
    localparam logic [2:0] CFG_SCALE_OUT = 3'd6;

    typedef struct packed {
        logic [2:0]  op_mode;
        logic [7:0]  zero_point_a;
        logic [7:0]  zero_point_b;
        logic [7:0]  zero_point_out;
        logic [31:0] scale_a;
        logic [31:0] scale_b;
        logic [31:0] scale_out;
    } cfg_t;

    typedef struct packed {
        logic              neg;
        logic              dz;
        logic              fixed;
        logic [QW-1:0]     fixq;
        logic [WW-1:0]     n;
        logic [WW-1:0]     d;
        logic [F24-1:0]    f;
        logic signed [7:0] ip;
    } front_t;

    typedef struct packed {
        front_t           it;
        logic [ACC_W-1:0] acc;
    } horn_t;

    typedef struct packed {
        logic          neg;
        logic          dz;
        logic          done;
        logic [QW-1:0] q;
        logic [RW-1:0] rem;
        logic [DW-1:0] den;
    } div_t;

    // Coefficients of the degree-7 polynomial for 2^f in Q24.
    function automatic logic [ACC_W-1:0] exp2_coef(input logic [2:0] k);
        logic [ACC_W-1:0] c;
        unique case (k)
            3'd0: c = ACC_W'(16777216);
            3'd1: c = ACC_W'(11629080);
            3'd2: c = ACC_W'(4030332);
            3'd3: c = ACC_W'(931204);
            3'd4: c = ACC_W'(161365);
            3'd5: c = ACC_W'(22370);
            3'd6: c = ACC_W'(2584);
            3'd7: c = ACC_W'(256);
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

>>> design/quantized_eltwise_uint8.sv
// Quantized uint8 element-wise unit: multiply, add, subtract, divide or exp.
// Input channel: in_valid / in_stall with operand_a and operand_b. One beat
// is taken at each edge where in_valid is high and in_stall is low.
// Output channel: out_valid / out_stall with quant_result, saturated and
// divide_by_zero, one beat per input beat, in order.
// Configuration: cfg_valid / cfg_ready with cfg_index and cfg_data; cfg_ready
// is always high. Write registers only while no beat is in flight.
// Throughput is one beat per cycle unless out_stall freezes the pipe: 4 front
// stages of dequantization and products, 7 stages of the exp polynomial, 2
// stages forming the quotient operands, 11 stages of restoring division (a cap
// check, then one quotient bit each) and the output register.
// All stages move together. When out_valid is high and out_stall is held,
// the whole pipe freezes and in_stall rises in the same cycle; nothing is
// dropped or repeated.
// Reset clears all valid bits and loads the register defaults: multiply
// mode, zero points 0 and all scales 1.0.
module quantized_eltwise_uint8
    import qe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  operand_a,
    input  logic [7:0]  operand_b,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  quant_result,
    output logic        saturated,
    output logic        divide_by_zero,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    cfg_t cfg_reg;
    logic advance;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            cfg_reg.op_mode        <= MODE_MUL;
            cfg_reg.zero_point_a   <= '0;
            cfg_reg.zero_point_b   <= '0;
            cfg_reg.zero_point_out <= '0;
            cfg_reg.scale_a        <= 32'(1) << SCALE_FRAC_BITS;
            cfg_reg.scale_b        <= 32'(1) << SCALE_FRAC_BITS;
            cfg_reg.scale_out      <= 32'(1) << SCALE_FRAC_BITS;
        end
        else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_OP_MODE:   cfg_reg.op_mode        <= cfg_data[2:0];
                CFG_ZP_A:      cfg_reg.zero_point_a   <= cfg_data[7:0];
                CFG_ZP_B:      cfg_reg.zero_point_b   <= cfg_data[7:0];
                CFG_ZP_OUT:    cfg_reg.zero_point_out <= cfg_data[7:0];
                CFG_SCALE_A:   cfg_reg.scale_a        <= cfg_data;
                CFG_SCALE_B:   cfg_reg.scale_b        <= cfg_data;
                CFG_SCALE_OUT: cfg_reg.scale_out      <= cfg_data;
                default: ;
            endcase
        end
    end

    logic out_valid_reg;
    assign advance  = !(out_valid_reg && out_stall);
    assign in_stall = !advance;

    // Front end.
    logic   fv;
    front_t fitem;

    qe_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (in_valid),
        .operand_a (operand_a),
        .operand_b (operand_b),
        .cfg       (cfg_reg),
        .out_valid (fv),
        .out_item  (fitem)
    );

    // Horner chain for 2^f.
    logic  hv [0:7];
    horn_t hs [0:7];

    assign hv[0]     = fv;
    assign hs[0].it  = fitem;
    assign hs[0].acc = exp2_coef(3'd7);

    for (genvar j = 0; j < 7; j++) begin : g_horner
        qe_horner_step u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .in_valid  (hv[j]),
            .in_item   (hs[j]),
            .coef_sel  (3'(6 - j)),
            .out_valid (hv[j+1]),
            .out_item  (hs[j+1])
        );
    end

    // Exp scaling by 2^n, then quotient operands.
    logic              p1v_reg, p2v_reg;
    front_t            p1_reg;
    front_t            p1_next;
    div_t              p2_reg;
    div_t              p2_next;
    logic signed [8:0] sh;
    logic [8:0]        sh_neg;

    assign sh     = $signed({hs[7].it.ip[7], hs[7].it.ip}) + 9'(SCALE_FRAC_BITS) - 9'(F24);
    assign sh_neg = 9'(-sh);

    always_comb begin
        p1_next = hs[7].it;
        if (cfg_reg.op_mode == MODE_EXP && !hs[7].it.fixed) begin
            if (!sh[8]) begin
                p1_next.n = WW'(hs[7].acc) << sh[7:0];
                p1_next.d = WW'(cfg_reg.scale_out);
            end
            else begin
                p1_next.n = WW'(hs[7].acc);
                p1_next.d = WW'(cfg_reg.scale_out) << sh_neg[7:0];
            end
        end
    end

    always_comb begin
        p2_next.neg  = p1_reg.neg;
        p2_next.dz   = p1_reg.dz;
        p2_next.done = p1_reg.fixed;
        p2_next.q    = p1_reg.fixed ? p1_reg.fixq : '0;
        p2_next.rem  = (RW'(p1_reg.n) << 1) + RW'(p1_reg.d);
        p2_next.den  = DW'(p1_reg.d) << 1;
        // A zero denominator saturates unless the numerator is zero too.
        if (!p1_reg.fixed && p1_reg.d == '0) begin
            p2_next.done = 1'b1;
            p2_next.q    = (p1_reg.n == '0) ? '0 : QCAP;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            p1v_reg <= 1'b0;
            p2v_reg <= 1'b0;
        end
        else if (advance) begin
            p1v_reg <= hv[7];
            p2v_reg <= p1v_reg;
        end
    end

    always_ff @(posedge clk) begin
        if (advance) begin
            p1_reg <= p1_next;
            p2_reg <= p2_next;
        end
    end

    // Restoring division, cap check first.
    logic dv [0:QW+1];
    div_t ds [0:QW+1];

    assign dv[0] = p2v_reg;
    assign ds[0] = p2_reg;

    for (genvar j = 0; j <= QW; j++) begin : g_div
        qe_div_step u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .in_valid  (dv[j]),
            .in_item   (ds[j]),
            .step      (4'(QW - j)),
            .out_valid (dv[j+1]),
            .out_item  (ds[j+1])
        );
    end

    // Output zero point and clamp.
    logic [7:0]         res_reg, res_next;
    logic               sat_reg, sat_next;
    logic               dz_reg, dz_next;
    logic signed [11:0] v;

    assign v = ds[QW+1].neg
        ? $signed({4'b0, cfg_reg.zero_point_out}) - $signed({2'b0, ds[QW+1].q})
        : $signed({4'b0, cfg_reg.zero_point_out}) + $signed({2'b0, ds[QW+1].q});

    always_comb begin
        res_next = v[7:0];
        sat_next = 1'b0;
        dz_next  = ds[QW+1].dz;
        if (cfg_reg.op_mode > MODE_EXP) begin
            res_next = '0;
            dz_next  = 1'b0;
        end
        else if (v < 0) begin
            res_next = '0;
            sat_next = 1'b1;
        end
        else if (v > 12'sd255) begin
            res_next = 8'hFF;
            sat_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end
        else if (advance) begin
            out_valid_reg <= dv[QW+1];
        end
    end

    always_ff @(posedge clk) begin
        if (advance) begin
            res_reg <= res_next;
            sat_reg <= sat_next;
            dz_reg  <= dz_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign quant_result   = res_reg;
    assign saturated      = sat_reg;
    assign divide_by_zero = dz_reg;

    a_dz_only_divide: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && divide_by_zero |-> cfg_reg.op_mode == MODE_DIV)
        else $error("divide_by_zero outside divide mode");

    a_sat_at_rail: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && saturated |-> quant_result == 8'd0 || quant_result == 8'd255)
        else $error("saturated flag with a result off the rails");

    a_bad_mode_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && cfg_reg.op_mode > MODE_EXP |-> quant_result == 8'd0 && !saturated)
        else $error("unused mode gave a nonzero result");

endmodule

>>> design/qe_front.sv
module qe_front
    import qe_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       advance,
    input  logic       in_valid,
    input  logic [7:0] operand_a,
    input  logic [7:0] operand_b,
    input  cfg_t       cfg,
    output logic       out_valid,
    output front_t     out_item
);

    logic v1_reg, v2_reg, v3_reg, v4_reg;

    // Stage 1: remove zero points.
    logic signed [8:0] da_reg, db_reg;
    // Stage 2: magnitudes times scales.
    logic [15:0] pab_reg;
    logic [39:0] ta_reg, tb_reg;
    logic [63:0] sab_reg;
    logic        na_reg, nb_reg;
    // Stage 3: second products and sums.
    logic [47:0]          plo_reg, phi_reg;
    logic [63:0]          dlo_reg;
    logic [39:0]          dhi_reg;
    logic [40:0]          sum_reg;
    logic                 sneg_reg;
    logic [39:0]          ta3_reg;
    logic                 dz3_reg, hi3_reg, lo3_reg, na3_reg, nb3_reg;
    logic signed [PW-1:0] pexp_reg;
    // Stage 4.
    front_t item_reg;

    logic [7:0]           mag_a, mag_b;
    logic signed [XW-1:0] xa, xb, s_ab;
    logic signed [TW-1:0] t_x;
    logic signed [PW-1:0] p_next;
    front_t               item_next;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (advance) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    assign mag_a = da_reg[8] ? 8'(-da_reg) : 8'(da_reg);
    assign mag_b = db_reg[8] ? 8'(-db_reg) : 8'(db_reg);

    assign xa = na_reg ? -$signed({2'b00, ta_reg}) : $signed({2'b00, ta_reg});
    assign xb = nb_reg ? -$signed({2'b00, tb_reg}) : $signed({2'b00, tb_reg});
    assign s_ab = (cfg.op_mode == MODE_SUB) ? xa - xb : xa + xb;
    // Only meaningful inside the exp range, where it fits.
    assign t_x = TW'(xa <<< (F24 - SCALE_FRAC_BITS));
    assign p_next = PW'(t_x) * PW'($signed({1'b0, LOG2E_Q28}));

    always_ff @(posedge clk) begin
        if (advance) begin
            da_reg <= $signed({1'b0, operand_a}) - $signed({1'b0, cfg.zero_point_a});
            db_reg <= $signed({1'b0, operand_b}) - $signed({1'b0, cfg.zero_point_b});

            pab_reg <= 16'(mag_a) * 16'(mag_b);
            ta_reg  <= 40'(mag_a) * 40'(cfg.scale_a);
            tb_reg  <= 40'(mag_b) * 40'(cfg.scale_b);
            sab_reg <= 64'(cfg.scale_a) * 64'(cfg.scale_b);
            na_reg  <= da_reg[8];
            nb_reg  <= db_reg[8];

            plo_reg  <= 48'(pab_reg) * 48'(sab_reg[31:0]);
            phi_reg  <= 48'(pab_reg) * 48'(sab_reg[63:32]);
            dlo_reg  <= 64'(tb_reg[31:0]) * 64'(cfg.scale_out);
            dhi_reg  <= 40'(tb_reg[39:32]) * 40'(cfg.scale_out);
            sum_reg  <= s_ab[XW-1] ? 41'(-s_ab) : 41'(s_ab);
            sneg_reg <= s_ab[XW-1];
            ta3_reg  <= ta_reg;
            dz3_reg  <= (tb_reg == '0);
            hi3_reg  <= (xa >= EXP_LIM);
            lo3_reg  <= (xa < -EXP_LIM);
            na3_reg  <= na_reg;
            nb3_reg  <= nb_reg;
            pexp_reg <= p_next;

            item_reg <= item_next;
        end
    end

    always_comb begin
        item_next       = '0;
        item_next.f     = pexp_reg[28+F24-1:28];
        item_next.ip    = 8'(pexp_reg >>> (28 + F24));
        unique case (cfg.op_mode)
            MODE_MUL: begin
                item_next.neg = na3_reg ^ nb3_reg;
                item_next.n   = WW'(plo_reg) + (WW'(phi_reg) << 32);
                item_next.d   = WW'(cfg.scale_out) << SCALE_FRAC_BITS;
            end
            MODE_ADD, MODE_SUB: begin
                item_next.neg = sneg_reg;
                item_next.n   = WW'(sum_reg);
                item_next.d   = WW'(cfg.scale_out);
            end
            MODE_DIV: begin
                item_next.dz  = dz3_reg;
                item_next.neg = dz3_reg ? na3_reg : (na3_reg ^ nb3_reg);
                item_next.n   = WW'(ta3_reg) << SCALE_FRAC_BITS;
                item_next.d   = WW'(dlo_reg) + (WW'(dhi_reg) << 32);
            end
            MODE_EXP: begin
                item_next.fixed = hi3_reg || lo3_reg;
                item_next.fixq  = hi3_reg ? QCAP : '0;
            end
            default: begin
                item_next.fixed = 1'b1;
            end
        endcase
    end

    assign out_valid = v4_reg;
    assign out_item  = item_reg;

endmodule

>>> design/qe_horner_step.sv
module qe_horner_step
    import qe_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       advance,
    input  logic       in_valid,
    input  horn_t      in_item,
    input  logic [2:0] coef_sel,
    output logic       out_valid,
    output horn_t      out_item
);

    logic                   valid_reg;
    horn_t                  item_reg;
    horn_t                  item_next;
    logic [ACC_W+F24-1:0]   prod;

    assign prod = (ACC_W + F24)'(in_item.acc) * (ACC_W + F24)'(in_item.it.f);

    always_comb begin
        item_next     = in_item;
        item_next.acc = ACC_W'(prod >> F24) + exp2_coef(coef_sel);
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end
        else if (advance) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk) begin
        if (advance) begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

>>> design/qe_div_step.sv
module qe_div_step
    import qe_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       advance,
    input  logic       in_valid,
    input  div_t       in_item,
    input  logic [3:0] step,
    output logic       out_valid,
    output div_t       out_item
);

    logic          valid_reg;
    div_t          item_reg;
    div_t          item_next;
    logic [RW-1:0] dsh;

    assign dsh = RW'(in_item.den) << step;

    // The top step only detects a quotient that reaches the cap.
    always_comb begin
        item_next = in_item;
        if (!in_item.done && in_item.rem >= dsh) begin
            if (step == 4'(QW)) begin
                item_next.done = 1'b1;
                item_next.q    = QCAP;
            end
            else begin
                item_next.rem = in_item.rem - dsh;
                item_next.q   = in_item.q | (QW'(1) << step);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end
        else if (advance) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk) begin
        if (advance) begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule
